// ----- design/slpq_pkg.sv -----
`default_nettype none

package slpq_pkg;

    // default capacity of the store
    localparam int DEPTH_DEF = 16;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [31:0] key_value;
        logic [3:0]  position;
    } req_t;

    typedef struct packed {
        logic [31:0] max_key;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } rsp_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/slpq_ctrl.sv -----
`default_nettype none

module slpq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output slpq_pkg::cmd_t    cmd
);
    import slpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.compare = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                // hold until the result register can take the new result
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ----- design/slpq_dpath.sv -----
`default_nettype none

module slpq_dpath #(
    parameter int DEPTH = slpq_pkg::DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire slpq_pkg::cmd_t  cmd,
    input  wire slpq_pkg::req_t  req_item,
    output slpq_pkg::rsp_t       rsp_item
);
    import slpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 4) ? CW : 4;
    localparam int XW = (CW > 5) ? CW : 5;

    // cell 0 holds the greatest key; keys descend toward higher cells
    logic [31:0]    cell_reg  [DEPTH];
    logic [31:0]    cell_next [DEPTH];
    logic [31:0]    shift_in  [DEPTH];
    logic [31:0]    up_in     [DEPTH];

    logic           op_reg;
    logic [31:0]    key_reg;
    logic [3:0]     pos_reg;

    logic [DEPTH-1:0] ge_reg, ge_next;
    logic [1:0]     st_reg, st_next;
    logic [CW-1:0]  q_reg, q_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [XW-1:0]  count_ext;
    rsp_t           rsp_reg, rsp_next;
    logic           do_update;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_item.opcode;
            key_reg <= req_item.key_value;
            pos_reg <= req_item.position;
        end
    end

    // parallel compare against every live cell
    always_comb
    begin
        for (int p = 0; p < DEPTH; p++)
            ge_next[p] = (CW'(p) < count_reg) && (cell_reg[p] >= key_reg);
    end

    always_comb
    begin
        q_next = count_reg - CW'(1) - CW'(pos_reg);
        priority if (op_reg == OP_INSERT)
            st_next = (count_reg == CW'(DEPTH)) ? ST_FULL : ST_OK;
        else if (count_reg == '0)
            st_next = ST_EMPTY;
        else if (PW'(pos_reg) >= PW'(count_reg))
            st_next = ST_RANGE;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            ge_reg <= ge_next;
            st_reg <= st_next;
            q_reg  <= q_next;
        end
    end

    assign do_update = cmd.commit && (st_reg == ST_OK);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign shift_in[g] = key_reg;
            end
            else
            begin : g_rest
                assign shift_in[g] = ge_reg[g-1] ? key_reg : cell_reg[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_top
                assign up_in[g] = cell_reg[g];
            end
            else
            begin : g_below
                assign up_in[g] = cell_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        for (int p = 0; p < DEPTH; p++)
        begin
            cell_next[p] = cell_reg[p];
            if (do_update)
            begin
                if (op_reg == OP_INSERT)
                    cell_next[p] = ge_reg[p] ? cell_reg[p] : shift_in[p];
                else if (CW'(p) >= q_reg)
                    cell_next[p] = up_in[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_update)
        begin
            if (op_reg == OP_INSERT)
                count_next = count_reg + CW'(1);
            else
                count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count_ext = XW'(count_next);

    always_comb
    begin
        rsp_next.max_key     = (do_update && op_reg == OP_REMOVE) ? cell_reg[0] : 32'd0;
        rsp_next.status      = st_reg;
        rsp_next.entry_count = count_ext[4:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp_item = rsp_reg;

endmodule

`default_nettype wire

// ----- design/sorted_list_priority_queue_core.sv -----
// a request transaction is taken only in idle; the controller then steps through compare
//   and update, and a new request waits until the update has committed the response;
//   the update waits while an unread response holds the output
// every cell compares and shifts in parallel, so the sequence does not depend on DEPTH
// reset: rst_n is asynchronous and active low; it empties the store and drops rsp_valid
`default_nettype none

module sorted_list_priority_queue_core #(
    parameter int DEPTH = slpq_pkg::DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire slpq_pkg::req_t  req_item,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output slpq_pkg::rsp_t       rsp_item
);
    import slpq_pkg::*;

    // command bundle from the sequencer to the compare/shift datapath
    cmd_t cmd;

    // sequencer: idle -> compare -> update, owns both handshakes
    slpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // key cells kept largest-first, so the greatest key sits in cell 0;
    // insert shifts the smaller keys up one cell, remove pulls the cells
    // above the removed one down, both in the update step
    slpq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_item (req_item),
        .rsp_item (rsp_item)
    );

endmodule

`default_nettype wire

// ----- design/slpq_checker.sv -----
`default_nettype none

module slpq_checker #(
    parameter int DEPTH = slpq_pkg::DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_ready,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_ready,
    input  wire slpq_pkg::rsp_t  rsp_item
);
    import slpq_pkg::*;

    // a pending response holds steady
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("response changed while stalled");

    // one transaction at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // errors never report a key
    a_err_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != ST_OK |-> rsp_item.max_key == 32'd0)
        else $error("error response carries a key");

    // full means the count sits at capacity
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status == ST_FULL |->
            (DEPTH > 31) || (rsp_item.entry_count == 5'(DEPTH)))
        else $error("full status with wrong count");

    // empty means nothing stored
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status == ST_EMPTY |-> rsp_item.entry_count == 5'd0)
        else $error("empty status with nonzero count");

endmodule

bind sorted_list_priority_queue_core slpq_checker #(
    .DEPTH (DEPTH)
) u_slpq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
);

`default_nettype wire
